[src/free_list_index_allocator_unit_defines.svh]
// Assertion macros used by the checker of the free-list allocator.
`ifndef FREE_LIST_INDEX_ALLOCATOR_UNIT_DEFINES_SVH
`define FREE_LIST_INDEX_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define FLA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fla assertion failed");

// Next-cycle implication, sampled on clk_i, quiet while rst_ni is low.
`define FLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fla assertion failed");

`endif

[src/fla_pkg.sv]
// Types and constants of the free-list index allocator.
package fla_pkg;

  // Table depth and widths.
  localparam int unsigned MaxSlots = 256;
  localparam int unsigned IdxW     = $clog2(MaxSlots);
  localparam int unsigned LinkW    = IdxW + 1;

  // A link or head value of MaxSlots marks the end of the list.
  localparam logic [LinkW-1:0] EmptyMark = LinkW'(MaxSlots);

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_POOL_SIZE = 1'b0,
    CFG_CLOSED    = 1'b1
  } cfg_reg_e;

  // Command kinds.
  typedef enum logic [0:0] {
    KIND_ACQUIRE = 1'b0,
    KIND_RELEASE = 1'b1
  } kind_e;

  // Result codes.
  typedef enum logic [2:0] {
    ST_GRANTED      = 3'd0,
    ST_EMPTY_RETRY  = 3'd1,
    ST_EMPTY_CLOSED = 3'd2,
    ST_RELEASED     = 3'd3,
    ST_REJECTED     = 3'd4
  } status_e;

  // One write into the link table.
  typedef struct packed {
    logic             en;
    logic [IdxW-1:0]  addr;
    logic [LinkW-1:0] data;
  } link_wr_t;

endpackage

[src/fla_link_table.sv]
// Next-link table with per-entry valid bits and a registered read port.
module fla_link_table
  import fla_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic [LinkW-1:0] pool_size_i,
  input  logic [IdxW-1:0]  rd_addr_i,
  input  link_wr_t         wr_i,
  output logic [LinkW-1:0] link_o
);

  logic [LinkW-1:0] mem [MaxSlots];
  logic [MaxSlots-1:0] vld_q, vld_d;
  logic [LinkW-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [IdxW-1:0]  rd_addr_q;
  logic [LinkW-1:0] addr_inc;
  logic [LinkW-1:0] dflt_link;

  // Storage write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  // Valid bits: a rebuild clears them all at once.
  always_comb begin
    vld_d = vld_q;
    if (clear_i) begin
      vld_d = '0;
    end else if (wr_i.en) begin
      vld_d[wr_i.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      vld_q    <= vld_d;
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  // An entry never written since the rebuild holds the initial chain.
  assign addr_inc  = {1'b0, rd_addr_q} + LinkW'(1);
  assign dflt_link = (addr_inc < pool_size_i) ? addr_inc : EmptyMark;
  assign link_o    = rd_vld_q ? rd_data_q : dflt_link;

endmodule

[src/free_list_index_allocator_unit.sv]
// Top level of the free-list index allocator: a LIFO stack of free slot indices.
//
// One command (acquire or release) is taken when start is high and busy is
// low. Busy is high for the cycle after the accepting edge, while the command
// executes; the result word then appears on status_o and granted_index_o
// with done_o high for exactly one cycle, registered from the execute flag.
// In that same cycle busy is low again, so a new command may be issued while
// done_o is high. The execute cycle waits for the registered read
// of the next-link table at the current head. Results cannot be held off
// by the receiver. The link table needs no clearing pass: after reset or a
// pool_size write, per-entry valid bits make every entry read as the
// initial chain. Configuration writes are meant for idle periods only; a
// pool_size write of zero is ignored and values above the table depth
// saturate.
module free_list_index_allocator_unit
  import fla_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_index_i,
  input  logic [8:0]       cfg_wdata_i,
  input  logic             start,
  output logic             busy,
  input  logic             kind_i,
  input  logic [8:0]       slot_index_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [7:0]       granted_index_o
);

  logic             accept;
  logic             exec_q;
  logic             kind_q;
  logic [LinkW-1:0] idx_q;
  logic [LinkW-1:0] head_q, head_d;
  logic [LinkW-1:0] pool_size_q;
  logic             closed_q;
  logic             rebuild;
  logic [LinkW-1:0] size_wr;
  logic [LinkW-1:0] link;
  logic             head_ok;
  link_wr_t         link_wr;
  status_e          status_d;
  status_e          status_q;
  logic [IdxW-1:0]  granted_d, granted_q;
  logic             done_q;

  assign accept = start && !busy;
  assign busy   = exec_q;

  // Saturate the pool size to the table depth.
  assign size_wr = (cfg_wdata_i > LinkW'(MaxSlots)) ? LinkW'(MaxSlots) : cfg_wdata_i;
  assign rebuild = cfg_we_i && (cfg_index_i == CFG_POOL_SIZE) && (cfg_wdata_i != '0);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= LinkW'(MaxSlots);
      closed_q    <= 1'b0;
    end else if (cfg_we_i) begin
      if (rebuild) begin
        pool_size_q <= size_wr;
      end
      if (cfg_index_i == CFG_CLOSED) begin
        closed_q <= cfg_wdata_i[0];
      end
    end
  end

  // Command register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      idx_q  <= slot_index_i;
    end
  end

  fla_link_table u_link_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (rebuild),
    .pool_size_i (pool_size_q),
    .rd_addr_i   (head_q[IdxW-1:0]),
    .wr_i        (link_wr),
    .link_o      (link)
  );

  assign head_ok = (head_q < pool_size_q);

  // Pop or push on the head, using the link read at the head.
  always_comb begin
    head_d       = head_q;
    status_d     = ST_REJECTED;
    granted_d    = '0;
    link_wr.en   = 1'b0;
    link_wr.addr = idx_q[IdxW-1:0];
    link_wr.data = head_ok ? head_q : EmptyMark;
    if (kind_q == KIND_ACQUIRE) begin
      if (!head_ok) begin
        status_d = closed_q ? ST_EMPTY_CLOSED : ST_EMPTY_RETRY;
      end else begin
        status_d  = ST_GRANTED;
        granted_d = head_q[IdxW-1:0];
        head_d    = (link < pool_size_q) ? link : EmptyMark;
      end
    end else begin
      if (idx_q < pool_size_q) begin
        status_d   = ST_RELEASED;
        link_wr.en = exec_q;
        head_d     = idx_q;
      end
    end
  end

  // Control state: execute flag, head and result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q <= 1'b0;
      done_q <= 1'b0;
      head_q <= '0;
    end else begin
      exec_q <= accept;
      done_q <= exec_q;
      if (rebuild) begin
        head_q <= '0;
      end else if (exec_q) begin
        head_q <= head_d;
      end
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (exec_q) begin
      status_q  <= status_d;
      granted_q <= granted_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign granted_index_o = granted_q;

endmodule

[src/fla_checker.sv]
// Port-level checker of the free-list index allocator and its bind.
`include "free_list_index_allocator_unit_defines.svh"

module fla_checker
  import fla_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [2:0] status_o,
  input logic [7:0] granted_index_o
);

  // An accepted command holds busy for the next cycle.
  `FLA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // The result word appears in the cycle after busy, with busy low again.
  `FLA_ASSERT_NEXT(a_busy_done, busy, done_o && !busy)
  // A result only appears after a busy cycle.
  `FLA_ASSERT_NOW(a_done_after_busy, done_o, $past(busy))
  // Only a grant carries a nonzero index.
  `FLA_ASSERT_NOW(a_idx_zero, done_o && (status_o != ST_GRANTED), granted_index_o == '0)
  // A result code is always one of the defined ones.
  `FLA_ASSERT_NOW(a_status_code, done_o,
                  (status_o == ST_GRANTED) || (status_o == ST_EMPTY_RETRY) ||
                  (status_o == ST_EMPTY_CLOSED) || (status_o == ST_RELEASED) ||
                  (status_o == ST_REJECTED))

endmodule

bind free_list_index_allocator_unit fla_checker u_fla_checker (.*);
